[hdl/efr_pkg.sv]
`default_nettype none

package efr_pkg;

	// Byte stuffing codes on the radio link.
	localparam logic [7:0] ESC_BYTE    = 8'hFF;
	localparam logic [7:0] ESC_LITERAL = 8'h00;
	localparam logic [7:0] ESC_START   = 8'h01;
	localparam logic [7:0] ESC_END     = 8'h02;

	// Bit positions of the flags in the mode byte.
	localparam int UNLOCK_BIT = 7;
	localparam int HEAD_BIT   = 6;

	// Frame layout: six payload bytes, then one checksum byte.
	localparam int          PAYLOAD_LEN = 6;
	localparam logic [3:0]  PAYLOAD_CNT = 4'd6;
	localparam logic [3:0]  FRAME_CNT   = 4'd7;
	localparam logic [3:0]  COUNT_MAX   = 4'd8;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Operations that the front hands to the back.
	typedef enum logic [1:0] {
		OP_OPEN,
		OP_CLOSE,
		OP_DATA,
		OP_BADESC
	} op_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_LENGTH   = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_ESCAPE   = 2'd3
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} entry_t;

endpackage

`default_nettype wire

[hdl/efr_front.sv]
`default_nettype none

// Removes the byte stuffing and turns the raw byte stream into operations.
module efr_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [7:0]       rx_byte,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             push_valid,
	output efr_pkg::entry_t  push_entry,
	input  wire              push_ready
);

	logic escape_q;
	logic accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	always_comb begin
		push_valid      = 1'b0;
		push_entry.op   = efr_pkg::OP_DATA;
		push_entry.data = rx_byte;
		if (accept) begin
			if (escape_q) begin
				push_valid = 1'b1;
				unique case (rx_byte)
					efr_pkg::ESC_START: push_entry.op = efr_pkg::OP_OPEN;
					efr_pkg::ESC_END: push_entry.op = efr_pkg::OP_CLOSE;
					efr_pkg::ESC_LITERAL: begin
						push_entry.op   = efr_pkg::OP_DATA;
						push_entry.data = efr_pkg::ESC_BYTE;
					end
					default: push_entry.op = efr_pkg::OP_BADESC;
				endcase
			end else if (rx_byte != efr_pkg::ESC_BYTE) begin
				push_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
		end else if (accept) begin
			escape_q <= !escape_q && (rx_byte == efr_pkg::ESC_BYTE);
		end
	end

endmodule

`default_nettype wire

[hdl/efr_queue.sv]
`default_nettype none

// Small first-in first-out queue of operations.
module efr_queue #(
	parameter int DEPTH = efr_pkg::QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	input  efr_pkg::entry_t  push_entry,
	output logic             push_ready,
	output logic             pop_valid,
	output efr_pkg::entry_t  pop_entry,
	input  wire              pop_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	efr_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");

endmodule

`default_nettype wire

[hdl/efr_back.sv]
`default_nettype none

// Carries out frame operations and holds the finished result.
module efr_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              pop_valid,
	input  efr_pkg::entry_t  pop_entry,
	output logic             pop_ready,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [1:0]       frame_status,
	output logic             unlock_flag,
	output logic             head_mode,
	output logic [7:0]       power_level,
	output logic signed [7:0] roll_cmd,
	output logic signed [7:0] pitch_cmd,
	output logic signed [7:0] yaw_cmd,
	output logic [7:0]       trim_bits
);

	logic             in_frame_q;
	logic [3:0]       count_q;
	logic [7:0]       sum_q;
	logic [7:0]       chk_q;
	logic             bad_q;
	logic [7:0]       payload_q [efr_pkg::PAYLOAD_LEN];

	logic             out_valid_q;
	efr_pkg::status_t status_q;
	logic             unlock_q;
	logic             head_q;
	logic [7:0]       power_q;
	logic [7:0]       roll_q;
	logic [7:0]       pitch_q;
	logic [7:0]       yaw_q;
	logic [7:0]       trim_q;

	logic             out_free;
	logic             do_pop;
	logic             load_out;
	logic             take;
	logic             has_value;
	efr_pkg::status_t status;

	assign out_free  = !out_valid_q || out_ready;
	// A close of an open frame waits for room in the output register.
	assign pop_ready = (pop_entry.op != efr_pkg::OP_CLOSE) || !in_frame_q || out_free;
	assign do_pop    = pop_valid && pop_ready;
	assign load_out  = do_pop && (pop_entry.op == efr_pkg::OP_CLOSE) && in_frame_q;
	assign take      = do_pop && in_frame_q &&
		((pop_entry.op == efr_pkg::OP_DATA) || (pop_entry.op == efr_pkg::OP_BADESC));
	assign has_value = (pop_entry.op == efr_pkg::OP_DATA);

	always_comb begin
		if (bad_q) begin
			status = efr_pkg::ST_ESCAPE;
		end else if (count_q != efr_pkg::FRAME_CNT) begin
			status = efr_pkg::ST_LENGTH;
		end else if (sum_q != chk_q) begin
			status = efr_pkg::ST_CHECKSUM;
		end else begin
			status = efr_pkg::ST_GOOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			sum_q      <= '0;
			chk_q      <= '0;
			bad_q      <= 1'b0;
		end else if (do_pop) begin
			unique case (pop_entry.op)
				efr_pkg::OP_OPEN: begin
					in_frame_q <= 1'b1;
					count_q    <= '0;
					sum_q      <= '0;
					chk_q      <= '0;
					bad_q      <= 1'b0;
				end
				efr_pkg::OP_CLOSE: begin
					in_frame_q <= 1'b0;
				end
				efr_pkg::OP_DATA, efr_pkg::OP_BADESC: begin
					if (take) begin
						if (!has_value) begin
							bad_q <= 1'b1;
						end else if (count_q < efr_pkg::PAYLOAD_CNT) begin
							sum_q <= sum_q + pop_entry.data;
						end else if (count_q == efr_pkg::PAYLOAD_CNT) begin
							chk_q <= pop_entry.data;
						end
						if (count_q < efr_pkg::COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_value && (count_q < efr_pkg::PAYLOAD_CNT)) begin
			payload_q[count_q[2:0]] <= pop_entry.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status;
			if (status == efr_pkg::ST_GOOD) begin
				unlock_q <= payload_q[0][efr_pkg::UNLOCK_BIT];
				head_q   <= payload_q[0][efr_pkg::HEAD_BIT];
				power_q  <= payload_q[1];
				roll_q   <= payload_q[2];
				pitch_q  <= payload_q[3];
				yaw_q    <= payload_q[4];
				trim_q   <= payload_q[5];
			end else begin
				unlock_q <= 1'b0;
				head_q   <= 1'b0;
				power_q  <= '0;
				roll_q   <= '0;
				pitch_q  <= '0;
				yaw_q    <= '0;
				trim_q   <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = status_q;
	assign unlock_flag  = unlock_q;
	assign head_mode    = head_q;
	assign power_level  = power_q;
	assign roll_cmd     = roll_q;
	assign pitch_cmd    = pitch_q;
	assign yaw_cmd      = yaw_q;
	assign trim_bits    = trim_q;

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= efr_pkg::COUNT_MAX)
		else $error("byte count above saturation value");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && pop_entry.op == efr_pkg::OP_CLOSE && !in_frame_q && !out_valid_q)
		|=> !out_valid_q)
		else $error("result produced for a close with no open frame");

	a_failed_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != efr_pkg::ST_GOOD) |->
		(!unlock_q && !head_q && power_q == '0 && roll_q == '0 && pitch_q == '0 &&
		 yaw_q == '0 && trim_q == '0))
		else $error("failed frame carries nonzero fields");

endmodule

`default_nettype wire

[hdl/escaped_frame_receiver.sv]
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// in       | in_valid / in_ready   | rx_byte
// out      | out_valid / out_ready | frame_status, unlock_flag, head_mode,
//          |                       | power_level, roll_cmd, pitch_cmd,
//          |                       | yaw_cmd, trim_bits
//
// One word is taken every cycle while the queue has room; the front decodes it
// on arrival and the back runs one queued operation per cycle unless a close
// waits on the output; a result is registered once its close leaves the queue.
// Reset clears the escape flag, the queue and the frame state.
// A waiting result stalls only the next close of an open frame; that close sits
// at the head of the queue, the queue fills behind it, and then in_ready drops.

module escaped_frame_receiver #(
	parameter int QUEUE_DEPTH = efr_pkg::QUEUE_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [7:0]        rx_byte,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [1:0]        frame_status,
	output logic              unlock_flag,
	output logic              head_mode,
	output logic [7:0]        power_level,
	output logic signed [7:0] roll_cmd,
	output logic signed [7:0] pitch_cmd,
	output logic signed [7:0] yaw_cmd,
	output logic [7:0]        trim_bits
);

	// Front to queue: one operation word per decoded escape or data byte.
	logic            push_valid;
	logic            push_ready;
	efr_pkg::entry_t push_entry;

	// Queue to back.
	logic            pop_valid;
	logic            pop_ready;
	efr_pkg::entry_t pop_entry;

	// The front strips the stuffing; a lone escape byte produces no operation.
	efr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	// The queue lets the front keep decoding while the back waits on the output.
	efr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	// The back keeps the frame state, checksum and payload, and grades the frame.
	efr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_entry    (pop_entry),
		.pop_ready    (pop_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_status (frame_status),
		.unlock_flag  (unlock_flag),
		.head_mode    (head_mode),
		.power_level  (power_level),
		.roll_cmd     (roll_cmd),
		.pitch_cmd    (pitch_cmd),
		.yaw_cmd      (yaw_cmd),
		.trim_bits    (trim_bits)
	);

endmodule

`default_nettype wire
